// ----- rtl/core/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the radix integer-to-text block
// Register codes, the job record passed from the front to the back, the
// configuration bundle and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int MAX_DIGITS_DEF = 64;
	localparam int VALUE_W        = 64;
	localparam int CFG_DATA_W     = 5;
	localparam int CFG_INDEX_W    = 2;
	localparam int CHAR_W         = 7;
	localparam int DIGIT_W        = 4;

	localparam logic [4:0] RADIX_RESET = 5'd10;
	localparam logic [4:0] RADIX_MIN   = 5'd2;
	localparam logic [4:0] RADIX_MAX   = 5'd16;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
	localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'h61;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIX    = 2'd0,
		REG_UNSIGNED = 2'd1,
		REG_LOWER    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [4:0] radix;
		logic       unsigned_mode;
		logic       lowercase_letters;
	} cfg_t;

	typedef struct packed {
		logic               negative;
		logic [VALUE_W-1:0] magnitude;
	} job_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic lower);
		logic [CHAR_W-1:0] base;
		base = lower ? ASCII_LOWER : ASCII_UPPER;
		if (d < 4'd10) begin
			digit_char = ASCII_ZERO + CHAR_W'(d);
		end else begin
			digit_char = base + CHAR_W'(d - 4'd10);
		end
	endfunction

	function automatic logic [4:0] clamp_radix(input logic [4:0] r);
		if (r < RADIX_MIN) begin
			clamp_radix = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			clamp_radix = RADIX_MAX;
		end else begin
			clamp_radix = r;
		end
	endfunction

endpackage

// ----- rtl/core/rti_if.sv -----
// ----------------------------------------------------------------------------
// rti_if: channel interfaces of the radix integer-to-text block
// Input channel carries one integer, output channel carries one character.
// ----------------------------------------------------------------------------
interface rti_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rti_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rti_out_if;
	logic                        valid;
	logic                        ready;
	logic [rti_pkg::CHAR_W-1:0]  char_code;
	logic                        minus_before;
	logic                        last_char;

	modport source (output valid, output char_code, output minus_before,
		output last_char, input ready);
	modport sink   (input valid, input char_code, input minus_before,
		input last_char, output ready);
endinterface

// ----- rtl/core/rti_ram.sv -----
// ----------------------------------------------------------------------------
// rti_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rti_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/rti_front.sv -----
// ----------------------------------------------------------------------------
// rti_front: input stage of the converter
// Accept an integer, classify its sign and register its magnitude.
// ----------------------------------------------------------------------------
module rti_front (
	input  logic              clk,
	input  logic              arst_n,
	rti_in_if.sink            din,
	input  rti_pkg::cfg_t     cfg,
	output logic              push_valid,
	input  logic              push_ready,
	output rti_pkg::job_t     push_job
);

	logic          v_s1;
	rti_pkg::job_t job_s1;
	logic          neg;

	assign din.ready  = !v_s1 || push_ready;
	assign neg        = !cfg.unsigned_mode && din.value[rti_pkg::VALUE_W-1];
	assign push_valid = v_s1;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.ready) begin
			v_s1 <= din.valid;
		end
	end

	// negate modulo 2^64; the most negative value wraps to 2^63
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			job_s1.negative  <= neg;
			job_s1.magnitude <= neg ? (~din.value + 1'b1) : din.value;
		end
	end

endmodule

// ----- rtl/core/rti_queue.sv -----
// ----------------------------------------------------------------------------
// rti_queue: two-entry job queue
// Decouple the input stage from the conversion engine.
// ----------------------------------------------------------------------------
module rti_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rti_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rti_pkg::job_t pop_job
);

	localparam int DEPTH = 2;

	rti_pkg::job_t entry_q [DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = cnt_q != 2'(DEPTH);
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_job    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH))
		else $error("job queue count above depth");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("job queue count did not follow a lone push");

endmodule

// ----- rtl/core/rti_back.sv -----
// ----------------------------------------------------------------------------
// rti_back: conversion engine
// Divide by the radix eight bits a cycle, store digits, emit them reversed.
// ----------------------------------------------------------------------------
module rti_back #(
	parameter int MAX_DIGITS = rti_pkg::MAX_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rti_pkg::cfg_t cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  rti_pkg::job_t pop_job,
	rti_out_if.source     dout
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int VW = rti_pkg::VALUE_W;
	localparam int DW = rti_pkg::DIGIT_W;
	localparam int STEPS = 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_LD   = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [VW-1:0]              work_q;
	logic [DW-1:0]              rem_q;
	logic [2:0]                 chunk_q;
	logic [CW-1:0]              ndig_q;
	logic [CW-1:0]              k_q;
	logic                       neg_q;
	logic                       ov_q;
	logic [rti_pkg::CHAR_W-1:0] char_q;
	logic                       minus_q;
	logic                       last_q;

	logic [4:0]    radix;
	logic [VW-1:0] work_d;
	logic [DW-1:0] rem_d;
	logic [CW-1:0] ndig_inc;
	logic [CW-1:0] raddr_full;
	logic [DW-1:0] rd_digit;
	logic          ram_we;
	logic          ram_re;
	logic          load;
	logic          is_last;

	assign radix = rti_pkg::clamp_radix(cfg.radix);

	// eight restoring steps of long division by a base of at most sixteen
	always_comb begin
		logic [4:0]    t;
		logic [DW-1:0] r;
		logic [VW-1:0] w;
		r = rem_q;
		w = work_q;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, w[VW-1]};
			w = {w[VW-2:0], 1'b0};
			if (t >= radix) begin
				t    = t - radix;
				w[0] = 1'b1;
			end
			r = t[DW-1:0];
		end
		work_d = w;
		rem_d  = r;
	end

	assign ndig_inc   = ndig_q + 1'b1;
	assign raddr_full = ndig_q - 1'b1 - k_q;
	assign ram_we     = (state_q == ST_DIV) && (chunk_q == 3'd7);
	assign ram_re     = state_q == ST_RD;
	assign pop_ready  = state_q == ST_IDLE;
	assign load       = (state_q == ST_LD) && (!ov_q || dout.ready);
	assign is_last    = (k_q + 1'b1) == ndig_q;

	rti_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DIGITS)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ndig_q[AW-1:0]),
		.wdata   (rem_d),
		.re      (ram_re),
		.raddr   (raddr_full[AW-1:0]),
		.rdata_q (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= 3'd0;
			ndig_q  <= '0;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						chunk_q <= 3'd0;
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + 3'd1;
					if (chunk_q == 3'd7) begin
						ndig_q <= ndig_inc;
						if (work_d == '0 || ndig_inc == CW'(MAX_DIGITS)) begin
							k_q     <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (load) begin
						k_q     <= k_q + 1'b1;
						state_q <= is_last ? ST_IDLE : ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			work_q <= pop_job.magnitude;
			neg_q  <= pop_job.negative;
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			work_q <= work_d;
			// restart the remainder for the next digit
			rem_q  <= (chunk_q == 3'd7) ? '0 : rem_d;
		end
		if (load) begin
			char_q  <= rti_pkg::digit_char(rd_digit, cfg.lowercase_letters);
			minus_q <= (k_q == '0) && neg_q;
			last_q  <= is_last;
		end
	end

	assign dout.valid        = ov_q;
	assign dout.char_code    = char_q;
	assign dout.minus_before = minus_q;
	assign dout.last_char    = last_q;

	a_ndig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= CW'(MAX_DIGITS))
		else $error("digit count above store depth");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_LD) |-> (k_q < ndig_q))
		else $error("emit index past digit count");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (state_q == ST_IDLE && last_q))
		else $error("final digit did not close the number");

endmodule

// ----- rtl/core/radix_integer_to_text.sv -----
// ----------------------------------------------------------------------------
// radix_integer_to_text: 64-bit integer to ASCII text in a base of 2 to 16
// Top level: configuration registers, input stage, job queue, engine.
// ----------------------------------------------------------------------------
// Usage
//   din carries one 64-bit integer per transaction (valid/ready). dout
//   carries one ASCII digit per transaction, most significant digit first;
//   minus_before flags the first digit of a negative number and last_char
//   flags the final digit. Zero gives the single digit '0'.
//   Write radix (index 0), unsigned_mode (index 1) and lowercase_letters
//   (index 2) through wr_en/wr_index/wr_data while no number is in flight.
//   A radix below 2 or above 16 is saturated; other indexes are ignored.
// Timing
//   The input stage and a two-entry queue take new numbers while the
//   engine works, so din stays ready until three numbers are pending.
//   The engine divides eight bits per cycle; it stores each finished
//   digit and repeats until the value is zero or the store is full,
//   then reads the digits back (ST_RD) and loads each into the output
//   register (ST_LD), most significant first. It takes the next number
//   from the queue once the last digit of the current one is loaded.
// Reset and stall
//   Reset empties the queue and engine and restores radix 10, signed mode,
//   upper case. A stalled dout holds its digit; the engine waits behind it.
// ----------------------------------------------------------------------------
module radix_integer_to_text #(
	parameter int MAX_DIGITS = rti_pkg::MAX_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [rti_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [rti_pkg::CFG_DATA_W-1:0]     wr_data,
	rti_in_if.sink                             din,
	rti_out_if.source                          dout
);

	rti_pkg::cfg_t cfg_q;

	logic          push_valid;
	logic          push_ready;
	rti_pkg::job_t push_job;
	logic          pop_valid;
	logic          pop_ready;
	rti_pkg::job_t pop_job;

	// configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix             <= rti_pkg::RADIX_RESET;
			cfg_q.unsigned_mode     <= 1'b0;
			cfg_q.lowercase_letters <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				rti_pkg::REG_RADIX:    cfg_q.radix             <= wr_data;
				rti_pkg::REG_UNSIGNED: cfg_q.unsigned_mode     <= wr_data[0];
				rti_pkg::REG_LOWER:    cfg_q.lowercase_letters <= wr_data[0];
				default: ;
			endcase
		end
	end

	// sign classification and negation
	rti_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// hold pending numbers while the engine is busy
	rti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// digit generation and reversed emission
	rti_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.dout      (dout)
	);

endmodule
